// ===== rtl/ddo_pkg.sv =====
// Shared constants and types for the differential drive odometry block.
`default_nettype none
package ddo_pkg;

  localparam int unsigned TRIG_ITER    = 24;
  localparam int unsigned FIELD_W      = 32;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned KDEG_W       = 27;
  localparam logic [KDEG_W-1:0] KDEG   = 27'd74961321;
  localparam logic [32:0] CORDIC_GAIN  = 33'd652032874;
  localparam logic [15:0] RADIUS_RST   = 16'd8960;
  localparam logic [15:0] TRACK_RST    = 16'd58880;

  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_TRACK  = 1'b1;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_DIV   = 6'b000100,
    S_CINIT = 6'b001000,
    S_CORD  = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/ddo_sermul.sv =====
// Bit-serial shift-add multiplier: one operand bit per cycle while step_i is high, LSB first.
`default_nettype none
module ddo_sermul #(
  parameter int unsigned MW = 32,
  parameter int unsigned NB = 42
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire logic [NB-1:0]    oper_i,
  input  wire logic             step_i,
  input  wire logic             rnd_i,
  input  wire logic [MW-1:0]    mcand_i,
  output logic      [MW+NB-1:0] prod_o
);

  logic [MW-1:0] acc_q, acc_d;
  logic [NB-1:0] low_q, low_d;
  logic [MW:0]   sum;

  always_comb begin
    sum   = {1'b0, acc_q} + (low_q[0] ? {1'b0, mcand_i} : '0) + {{MW{1'b0}}, rnd_i};
    acc_d = acc_q;
    low_d = low_q;
    if (load_i) begin
      acc_d = '0;
      low_d = oper_i;
    end else if (step_i) begin
      acc_d = sum[MW:1];
      low_d = {sum[0], low_q[NB-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q <= low_d;
  end

  assign prod_o = {acc_q, low_q};

endmodule
`default_nettype wire

// ===== rtl/differential_drive_odometry.sv =====
// Top level of the differential drive midpoint odometry tracker.
`default_nettype none
// Takes one sample at a time. A sample that follows one with a positive
// timestamp passes through the setup state, bit-serial remainder and
// fraction division by 360*track (the distance multiply runs beside it),
// CORDIC init and rotations, the bit-serial cos/sin multiply and a step to
// close it, the pose write and the return to idle. A sample after a
// non-positive timestamp goes straight to the pose write. The pose write
// waits while an earlier result is held by out_stall_i. A finished result
// sits in an output register, so the next sample is taken while it waits.
module differential_drive_odometry #(
  parameter int unsigned TRIG_ITERATIONS = ddo_pkg::TRIG_ITER
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [ddo_pkg::FIELD_W-1:0] timestamp_i,
  input  wire logic signed [ddo_pkg::FIELD_W-1:0] right_wheel_angle_i,
  input  wire logic signed [ddo_pkg::FIELD_W-1:0] left_wheel_angle_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [ddo_pkg::FIELD_W-1:0] pose_x_out_o,
  output logic signed [ddo_pkg::FIELD_W-1:0] pose_y_out_o,
  output logic        [ddo_pkg::FIELD_W-1:0] heading_out_o,
  output logic                            updated_o,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [ddo_pkg::CFG_W-1:0]  cfg_data_i
);
  import ddo_pkg::*;

  state_e state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [15:0] radius_q, track_q;
  logic [31:0] prev_r_q, prev_l_q;
  logic        prev_pos_q;
  logic signed [31:0] dr_q, dl_q;
  logic        upd_q;
  logic signed [31:0] pos_x_q, pos_y_q;
  logic [31:0] head_q;
  logic [47:0] qmag_q, qmag_d;
  logic        qneg_q, dneg_q;
  logic [24:0] d_q, rem_q, rem_d;
  logic [31:0] quo_q, quo_d, half_q, half_d, full_q, full_d;
  logic        flip_q;
  logic signed [32:0] x_q, y_q, x_d, y_d;
  logic signed [33:0] z_q, z_d;
  logic        out_valid_q;

  // setup arithmetic
  logic signed [32:0] dsub, dsum;
  logic [31:0] dsub_mag;
  logic [32:0] dsum_mag;
  logic [47:0] amag;
  logic [48:0] qprod;

  // division
  logic [25:0] rem_t;
  logic        ge;
  logic [24:0] rem_s;
  logic        rnd_up;

  // cordic
  logic [31:0] ang, ang_f;
  logic [4:0]  sh;
  logic signed [32:0] xs, ys;
  logic [31:0] atan_v;

  // multiplies
  logic [74:0] prod_a;
  logic [73:0] prod_x, prod_y;
  logic [41:0] dist_mag;
  logic signed [32:0] c_s, s_s;
  logic [32:0] c_abs, s_abs;
  logic        xneg, yneg;
  logic        a_step, m_step, m_load;

  // final
  logic [43:0] dx_mag, dy_mag;
  logic signed [46:0] new_x, new_y;
  logic signed [31:0] sat_x, sat_y;
  logic        fin_go;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  assign dsub     = 33'(dr_q) - 33'(dl_q);
  assign dsum     = 33'(dr_q) + 33'(dl_q);
  assign dsub_mag = dsub[32] ? 32'(-dsub) : dsub[31:0];
  assign dsum_mag = dsum[32] ? 33'(-dsum) : 33'(dsum);
  assign amag     = dsub_mag * radius_q;
  assign qprod    = dsum_mag * radius_q;

  assign a_step   = (state_q == S_DIV) && (cnt_q < 7'd48);
  assign m_load   = (state_q == S_CINIT);
  assign m_step   = (state_q == S_CORD) && (cnt_q >= 7'(TRIG_ITERATIONS)) && !fin_go;

  ddo_sermul #(.MW(KDEG_W), .NB(48)) u_mul_dist (
    .clk_i, .rst_ni,
    .load_i (state_q == S_SETUP),
    .oper_i (amag),
    .step_i (a_step),
    .rnd_i  (cnt_q == 7'd32),
    .mcand_i(KDEG),
    .prod_o (prod_a)
  );
  assign dist_mag = prod_a[74:33];

  // cos/sin after quadrant unfold; the multiply phase reuses the CORD state
  assign c_s   = flip_q ? -x_q : x_q;
  assign s_s   = flip_q ? -y_q : y_q;
  assign c_abs = c_s[32] ? 33'(-c_s) : 33'(c_s);
  assign s_abs = s_s[32] ? 33'(-s_s) : 33'(s_s);
  assign xneg  = dneg_q ^ c_s[32];
  assign yneg  = dneg_q ^ s_s[32];

  ddo_sermul #(.MW(32), .NB(42)) u_mul_x (
    .clk_i, .rst_ni,
    .load_i (m_load),
    .oper_i (dist_mag),
    .step_i (m_step),
    .rnd_i  (cnt_q == 7'(TRIG_ITERATIONS + 29)),
    .mcand_i(c_abs[31:0]),
    .prod_o (prod_x)
  );

  ddo_sermul #(.MW(32), .NB(42)) u_mul_y (
    .clk_i, .rst_ni,
    .load_i (m_load),
    .oper_i (dist_mag),
    .step_i (m_step),
    .rnd_i  (cnt_q == 7'(TRIG_ITERATIONS + 29)),
    .mcand_i(s_abs[31:0]),
    .prod_o (prod_y)
  );

  assign dx_mag = prod_x[73:30];
  assign dy_mag = prod_y[73:30];
  assign new_x  = 47'(pos_x_q) + (xneg ? -47'(dx_mag) : 47'(dx_mag));
  assign new_y  = 47'(pos_y_q) + (yneg ? -47'(dy_mag) : 47'(dy_mag));

  always_comb begin
    if (new_x > 47'sd2147483647)       sat_x = 32'sh7fffffff;
    else if (new_x < -47'sd2147483648) sat_x = 32'sh80000000;
    else                               sat_x = new_x[31:0];
    if (new_y > 47'sd2147483647)       sat_y = 32'sh7fffffff;
    else if (new_y < -47'sd2147483648) sat_y = 32'sh80000000;
    else                               sat_y = new_y[31:0];
  end

  assign fin_go = (state_q == S_CORD) && (cnt_q == 7'(TRIG_ITERATIONS + 42));

  // division datapath
  always_comb begin
    rem_t  = (cnt_q < 7'd48) ? {rem_q, qmag_q[47]} : {rem_q, 1'b0};
    ge     = (rem_t >= {1'b0, d_q});
    rem_s  = ge ? 25'(rem_t - {1'b0, d_q}) : rem_t[24:0];
    rnd_up = ({rem_s, 1'b0} >= {1'b0, d_q});
  end

  assign ang   = head_q + half_q;
  assign ang_f = ang ^ {(ang[31] ^ ang[30]), 31'd0};
  assign sh    = cnt_q[4:0];
  assign xs    = x_q >>> sh;
  assign ys    = y_q >>> sh;
  assign atan_v = ATAN_TAB[sh];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    qmag_d  = qmag_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    half_d  = half_q;
    full_d  = full_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = prev_pos_q ? S_SETUP : S_FIN;
        end
      end
      S_SETUP: begin
        qmag_d  = qprod[47:0];
        rem_d   = '0;
        quo_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q < 7'd48) begin
          qmag_d = {qmag_q[46:0], 1'b0};
          rem_d  = rem_s;
        end else if (cnt_q == 7'd48) begin
          // fold the truncated remainder of a negative numerator to floor form
          if (qneg_q && (rem_q != '0)) rem_d = d_q - rem_q;
        end else begin
          rem_d = rem_s;
          quo_d = {quo_q[30:0], ge};
          if (cnt_q == 7'd79) half_d = (d_q == '0) ? '0 : quo_d + 32'(rnd_up);
          if (cnt_q == 7'd80) begin
            full_d  = (d_q == '0) ? '0 : quo_d + 32'(rnd_up);
            state_d = S_CINIT;
          end
        end
      end
      S_CINIT: begin
        x_d     = CORDIC_GAIN;
        y_d     = '0;
        z_d     = 34'($signed(ang_f));
        cnt_d   = '0;
        state_d = S_CORD;
      end
      S_CORD: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q < 7'(TRIG_ITERATIONS)) begin
          if (!z_q[33]) begin
            x_d = x_q - ys;
            y_d = y_q + xs;
            z_d = z_q - 34'(atan_v);
          end else begin
            x_d = x_q + ys;
            y_d = y_q - xs;
            z_d = z_q + 34'(atan_v);
          end
        end
        if (fin_go) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      radius_q    <= RADIUS_RST;
      track_q     <= TRACK_RST;
      prev_r_q    <= '0;
      prev_l_q    <= '0;
      prev_pos_q  <= 1'b0;
      upd_q       <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RADIUS: radius_q <= cfg_data_i;
          REG_TRACK:  track_q  <= cfg_data_i;
          default:    ;
        endcase
      end
      if (state_q == S_IDLE && in_valid_i) begin
        prev_r_q   <= right_wheel_angle_i;
        prev_l_q   <= left_wheel_angle_i;
        prev_pos_q <= (timestamp_i > 32'sd0);
        upd_q      <= prev_pos_q;
      end
      if (state_q == S_FIN && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
        if (upd_q) begin
          pos_x_q <= sat_x;
          pos_y_q <= sat_y;
          head_q  <= head_q + full_q;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qmag_q <= qmag_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    half_q <= half_d;
    full_q <= full_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    if (state_q == S_IDLE && in_valid_i) begin
      dr_q <= right_wheel_angle_i - prev_r_q;
      dl_q <= left_wheel_angle_i - prev_l_q;
    end
    if (state_q == S_SETUP) begin
      dneg_q <= dsub[32];
      qneg_q <= dsum[32];
      d_q    <= 25'(track_q) * 25'd360;
    end
    if (state_q == S_CINIT) flip_q <= ang[31] ^ ang[30];
    if (state_q == S_FIN && (!out_valid_q || !out_stall_i)) begin
      pose_x_out_o  <= upd_q ? sat_x : pos_x_q;
      pose_y_out_o  <= upd_q ? sat_y : pos_y_q;
      heading_out_o <= upd_q ? head_q + full_q : head_q;
      updated_o     <= upd_q;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_differential_drive_odometry.sv =====
// Self-checking testbench for the differential drive midpoint odometry tracker.
`default_nettype none
module tb_differential_drive_odometry;
  timeunit 1ns;
  timeprecision 1ps;
  import ddo_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [31:0] heading;
    logic               updated;
  } pose_t;

  class odometry_scoreboard;
    bit [15:0]   radius;
    bit [15:0]   track;
    bit [31:0]   last_right;
    bit [31:0]   last_left;
    bit          last_time_pos;
    int          pos_x;
    int          pos_y;
    bit [31:0]   heading;
    pose_t       pose_q[$];
    int          errors;

    function new();
      radius = RADIUS_RST;
      track  = TRACK_RST;
      last_right = 0;
      last_left = 0;
      last_time_pos = 0;
      pos_x = 0;
      pos_y = 0;
      heading = 0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, bit [15:0] val);
      if (idx == REG_RADIUS) radius = val;
      else track = val;
    endfunction

    // round(a*b / 2^s), half away from zero
    function longint round_mul_shr(longint a, longint b, int s);
      logic signed [127:0] pa, pb, p;
      logic [127:0] mag;
      longint m;
      pa = a;
      pb = b;
      p = pa * pb;
      mag = (p < 0) ? -p : p;
      mag = (mag + (128'd1 << (s - 1))) >> s;
      m = longint'(mag);
      return (p < 0) ? -m : m;
    endfunction

    function bit [31:0] turn_of(longint q, int sh);
      longint d, r;
      bit [63:0] v;
      if (track == 0) return 0;
      d = 360 * longint'(track);
      r = q % d;
      if (r < 0) r += d;
      v = ((r << sh) + d / 2) / d;
      return v[31:0];
    endfunction

    function void sin_cos(bit [31:0] ang, output longint c, output longint s);
      bit flip;
      longint x, y, z, nx;
      flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      if (flip) ang += 32'h8000_0000;
      z = longint'($signed(ang));
      x = longint'(CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < TRIG_ITER; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(ATAN_TAB[i]);
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(ATAN_TAB[i]);
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
    endfunction

    function void note_sample(bit [31:0] ts, bit [31:0] rgt, bit [31:0] lft);
      longint dr, dl, arc_mean, q, c, s;
      bit [31:0] full, half;
      pose_t p;
      p.updated = 0;
      if (last_time_pos) begin
        dr = longint'($signed(rgt - last_right));
        dl = longint'($signed(lft - last_left));
        arc_mean = round_mul_shr((dr - dl) * longint'(radius), longint'(KDEG), 33);
        q = (dr + dl) * longint'(radius);
        full = turn_of(q, 32);
        half = turn_of(q, 31);
        sin_cos(heading + half, c, s);
        pos_x = clamp32(longint'(pos_x) + round_mul_shr(arc_mean, c, 30));
        pos_y = clamp32(longint'(pos_y) + round_mul_shr(arc_mean, s, 30));
        heading += full;
        p.updated = 1;
      end
      last_right = rgt;
      last_left = lft;
      last_time_pos = $signed(ts) > 0;
      p.x = pos_x;
      p.y = pos_y;
      p.heading = heading;
      pose_q.push_back(p);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_pose(pose_t got);
      pose_t want;
      if (pose_q.size() == 0) begin
        report("unexpected result", got.x, 0);
        return;
      end
      want = pose_q.pop_front();
      if (got.x != want.x) report("pose_x", got.x, want.x);
      if (got.y != want.y) report("pose_y", got.y, want.y);
      if (got.heading != want.heading) report("heading", got.heading, want.heading);
      if (got.updated != want.updated) report("updated", got.updated, want.updated);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic signed [31:0] timestamp_i = 0;
  logic signed [31:0] right_wheel_angle_i = 0;
  logic signed [31:0] left_wheel_angle_i = 0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic signed [31:0] pose_x_out_o;
  logic signed [31:0] pose_y_out_o;
  logic [31:0] heading_out_o;
  logic updated_o;
  logic cfg_we_i = 0;
  logic cfg_idx_i = REG_RADIUS;
  logic [CFG_W-1:0] cfg_data_i = 0;

  differential_drive_odometry dut (.*);

  always #6 clk_i = ~clk_i;

  odometry_scoreboard pose_sb = new();
  bit no_idle = 0;
  bit hold_req = 0;
  int cycles = 0;
  bit [31:0] wheel_r = 0;
  bit [31:0] wheel_l = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stall per transfer, one long hold-off on request
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 17);
      if (hold_req) begin
        w = 3000;
        hold_req = 0;
      end
      if (w > 0) begin
        out_stall_i <= 1;
        repeat (w) @(posedge clk_i);
        out_stall_i <= 0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      pose_sb.check_pose({pose_x_out_o, pose_y_out_o, heading_out_o, updated_o});
    end
  end

  task send_sample(bit [31:0] ts, bit [31:0] rgt, bit [31:0] lft);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    timestamp_i <= ts;
    right_wheel_angle_i <= rgt;
    left_wheel_angle_i <= lft;
    do @(posedge clk_i); while (in_stall_o);
    pose_sb.note_sample(ts, rgt, lft);
  endtask

  task drain();
    in_valid_i <= 0;
    do @(posedge clk_i); while (pose_sb.pose_q.size() != 0);
    repeat (200) @(posedge clk_i);
  endtask

  task write_reg(logic idx, bit [15:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    pose_sb.set_reg(idx, val);
  endtask

  task random_sample();
    bit [31:0] ts;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) ts = ($urandom_range(0, 1) != 0) ? 32'd0 : ($urandom | 32'h8000_0000);
    else ts = $urandom_range(1, 32'h7fff_ffff);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      wheel_r = $urandom;
      wheel_l = $urandom;
    end else if (pick < 25) begin
      wheel_r += $urandom_range(0, 2000);
      wheel_l += $urandom_range(0, 2000);
    end else begin
      wheel_r += $urandom_range(0, 400) - 200;
      wheel_l += $urandom_range(0, 400) - 200;
    end
    send_sample(ts, wheel_r, wheel_l);
  endtask

  initial begin
    bit [15:0] radii[6];
    bit [15:0] tracks[6];
    radii = '{RADIUS_RST, 16'd1, 16'hffff, 16'hffff, 16'd1, 16'd0};
    tracks = '{TRACK_RST, 16'd1, 16'hffff, 16'd1, 16'hffff, 16'd0};
    radii[5] = 16'($urandom_range(1, 65535));
    tracks[5] = 16'($urandom_range(1, 65535));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    write_reg(REG_RADIUS, radii[0]);
    write_reg(REG_TRACK, tracks[0]);
    // first-sample guard, then extreme and wrapping deltas
    send_sample(32'd0, 32'd100, 32'd100);
    send_sample(32'h8000_0000, 32'd200, 32'd0);
    send_sample(32'h7fff_ffff, 32'd0, 32'd0);
    send_sample(32'd1, 32'd0, 32'd0);
    send_sample(32'd5, 32'd360, -32'sd360);
    send_sample(32'd6, 32'd360, -32'sd360);
    send_sample(32'd7, 32'd720, 32'd0);
    send_sample(32'd8, 32'h7fff_ffff, 32'h8000_0000);
    send_sample(32'd9, 32'hffff_ffff, 32'hffff_ffff);
    send_sample(32'd10, 32'h8000_0000, 32'h7fff_ffff);
    send_sample(32'd11, 32'h0000_0000, 32'hffff_ffff);
    send_sample(32'hffff_fff0, 32'd90, 32'd90);
    send_sample(32'd12, 32'd1000, -32'sd500);
    send_sample(32'd13, 32'd1000, -32'sd500);

    for (int ph = 1; ph < 6; ph++) begin
      drain();
      write_reg(REG_RADIUS, radii[ph]);
      write_reg(REG_TRACK, tracks[ph]);
      no_idle = (ph == 4);
      for (int n = 0; n < 100; n++) begin
        if (ph == 2 && n == 10) hold_req = 1;
        if (ph == 3 && n == 50) begin
          // let every pending result come out before resuming
          in_valid_i <= 0;
          do @(posedge clk_i); while (pose_sb.pose_q.size() != 0);
        end
        random_sample();
      end
    end
    no_idle = 0;
    drain();

    if (pose_sb.errors == 0 && pose_sb.pose_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/ddo_pkg.sv
rtl/ddo_sermul.sv
rtl/differential_drive_odometry.sv
tb/sv/tb_differential_drive_odometry.sv
